>>> design/abkf_pkg.sv
package abkf_pkg;

  typedef enum logic [5:0] {
    OP_NONE = 6'b000001,
    OP_ADD  = 6'b000010,
    OP_SUB  = 6'b000100,
    OP_MUL  = 6'b001000,
    OP_DIV  = 6'b010000,
    OP_MOV  = 6'b100000
  } alu_op_t;

  // register file addresses
  typedef enum logic [3:0] {
    R_ANGLE = 4'd0,
    R_BIAS  = 4'd1,
    R_PAA   = 4'd2,
    R_PAB   = 4'd3,
    R_PBA   = 4'd4,
    R_PBB   = 4'd5,
    R_ACC   = 4'd6,
    R_GYRO  = 4'd7,
    R_ERR   = 4'd8,
    R_T0    = 4'd9,
    R_T1    = 4'd10,
    R_E     = 4'd11,
    R_K0    = 4'd12,
    R_K1    = 4'd13,
    R_TMP   = 4'd14,
    R_ZERO  = 4'd15
  } reg_addr_t;

  // operand sources beyond the register file
  typedef enum logic [2:0] {
    S_REG  = 3'd0,
    S_QA   = 3'd1,
    S_QB   = 3'd2,
    S_R    = 3'd3,
    S_DT   = 3'd4
  } src_sel_t;

  typedef struct packed {
    alu_op_t   op;
    src_sel_t  sa;
    reg_addr_t ra;
    src_sel_t  sb;
    reg_addr_t rb;
    reg_addr_t rd;
    logic      start;
    logic      load_in;
    logic      gain_zero;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic e_pos;
  } dp_status_t;

  localparam int NUM_CFG = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PROG_LEN = 32;
  localparam int PC_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W:0] CFG_QA = 3'd0;
  localparam logic [CFG_IDX_W:0] CFG_QB = 3'd1;
  localparam logic [CFG_IDX_W:0] CFG_R  = 3'd2;
  localparam logic [CFG_IDX_W:0] CFG_DT = 3'd3;

endpackage

>>> design/abkf_datapath.sv
module abkf_datapath
  import abkf_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  logic [W-1:0]     acc_in,
  input  logic [W-1:0]     gyro_in,
  input  logic [W-2:0]     qa,
  input  logic [W-2:0]     qb,
  input  logic [W-2:0]     rn,
  input  logic [W-2:0]     dt,
  output dp_status_t       status,
  output logic [W-1:0]     angle_out,
  output logic [W-1:0]     rate_src
);

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam int MW = 2 * W;
  localparam int NW = W + F;
  localparam int CW = $clog2(NW + 1);
  localparam int HW = W / 2;
  localparam int LW = W - HW;

  logic signed [W-1:0] rf [16];

  logic signed [W-1:0] a_op, b_op, alu_res;
  reg_addr_t           dst;

  // multi-cycle unit state
  logic            mbusy, dbusy;
  logic [1:0]      mstep;
  logic [W-1:0]    mx, my;
  logic [MW-1:0]   macc;
  logic            mneg;
  logic [NW-1:0]   dnum;
  logic [W:0]      drem;
  logic [W-1:0]    dden;
  logic [NW-1:0]   dq;
  logic [CW-1:0]   dcnt;
  logic            dneg;

  // output holding registers
  logic [W-1:0]    angle_q, rate_q;

  function automatic logic signed [W-1:0] sel(src_sel_t s, reg_addr_t r);
    logic signed [W-1:0] v;
    unique case (s)
      S_QA:    v = $signed({1'b0, qa});
      S_QB:    v = $signed({1'b0, qb});
      S_R:     v = $signed({1'b0, rn});
      S_DT:    v = $signed({1'b0, dt});
      default: v = (r == R_ZERO) ? '0 : rf[r];
    endcase
    return v;
  endfunction

  function automatic logic signed [W-1:0] fit(logic neg, logic [MW-1:0] m);
    logic signed [W-1:0] v;
    if (neg) begin
      if (m > MW'({1'b0, VMAX}) ) v = VMIN;
      else v = W'(-$signed(m[W-1:0]));
    end else begin
      if (m > MW'({1'b0, VMAX})) v = VMAX;
      else v = m[W-1:0];
    end
    return v;
  endfunction

  assign a_op = sel(cmd.sa, cmd.ra);
  assign b_op = sel(cmd.sb, cmd.rb);

  logic signed [W:0] sum_w;
  always_comb begin
    if (cmd.op == OP_SUB) sum_w = {a_op[W-1], a_op} - {b_op[W-1], b_op};
    else sum_w = {a_op[W-1], a_op} + {b_op[W-1], b_op};
    if (sum_w[W] != sum_w[W-1]) alu_res = sum_w[W] ? VMIN : VMAX;
    else alu_res = sum_w[W-1:0];
  end

  // partial products: 4 steps of half x half
  logic [W-1:0]  pp;
  logic [HW-1:0] ph_x, ph_y;
  always_comb begin
    ph_x = mstep[1] ? HW'(mx[W-1:LW]) : HW'(mx[LW-1:0]);
    ph_y = mstep[0] ? HW'(my[W-1:LW]) : HW'(my[LW-1:0]);
    pp = W'(ph_x) * W'(ph_y);
  end
  logic [6:0] pshift;
  always_comb pshift = 7'((mstep[1] ? LW : 0) + (mstep[0] ? LW : 0));

  logic [W:0] rsh;
  assign rsh = {drem[W-1:0], dnum[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      dbusy <= 1'b0;
      angle_q <= '0;
      rate_q  <= '0;
      rf[R_ANGLE] <= '0;
      rf[R_BIAS]  <= '0;
      rf[R_PAA]   <= W'(1) << F;
      rf[R_PAB]   <= '0;
      rf[R_PBA]   <= '0;
      rf[R_PBB]   <= W'(1) << F;
    end else begin
      if (cmd.load_in) begin
        rf[R_ACC]  <= acc_in;
        rf[R_GYRO] <= gyro_in;
      end
      if (cmd.out_load) begin
        angle_q <= rf[R_ANGLE];
        rate_q  <= rf[R_TMP];
      end
      if (cmd.gain_zero) begin
        rf[R_K0] <= '0;
        rf[R_K1] <= '0;
      end
      if (cmd.start) begin
        dst <= cmd.rd;
        unique case (cmd.op)
          OP_ADD, OP_SUB: rf[cmd.rd] <= alu_res;
          OP_MOV:         rf[cmd.rd] <= a_op;
          OP_MUL: begin
            mx    <= a_op[W-1] ? W'(-a_op) : a_op;
            my    <= b_op[W-1] ? W'(-b_op) : b_op;
            mneg  <= a_op[W-1] ^ b_op[W-1];
            macc  <= '0;
            mstep <= 2'd0;
            mbusy <= 1'b1;
          end
          OP_DIV: begin
            dnum  <= NW'($unsigned(a_op[W-1] ? W'(-a_op) : a_op)) << F;
            dneg  <= a_op[W-1];
            dden  <= b_op;
            drem  <= '0;
            dq    <= '0;
            dcnt  <= CW'(NW);
            dbusy <= 1'b1;
          end
          default: ;
        endcase
      end
      if (mbusy) begin
        macc  <= macc + (MW'(pp) << pshift);
        mstep <= mstep + 2'd1;
        if (mstep == 2'd3) begin
          mbusy <= 1'b0;
          rf[dst] <= fit(mneg, ((macc + (MW'(pp) << pshift)) + (MW'(1) << (F - 1))) >> F);
        end
      end
      if (dbusy) begin
        dnum <= dnum << 1;
        if (rsh >= {1'b0, dden}) begin
          drem <= rsh - {1'b0, dden};
          dq   <= {dq[NW-2:0], 1'b1};
        end else begin
          drem <= rsh;
          dq   <= {dq[NW-2:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
        if (dcnt == CW'(1)) begin
          dbusy <= 1'b0;
          rf[dst] <= fit(dneg, MW'({dq[NW-2:0], (rsh >= {1'b0, dden})}));
        end
      end
    end
  end

  assign status.busy  = mbusy | dbusy;
  assign status.e_pos = !rf[R_E][W-1] && (rf[R_E] != '0);
  assign angle_out    = angle_q;
  assign rate_src     = rate_q;

endmodule

>>> design/abkf_ctrl.sv
module abkf_ctrl
  import abkf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        out_fire,
  input  dp_status_t  status,
  output dp_cmd_t     cmd,
  output logic        in_ready,
  output logic        out_valid
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  dp_cmd_t ins;

  function automatic dp_cmd_t mk(alu_op_t o, src_sel_t sa, reg_addr_t ra,
                                 src_sel_t sb, reg_addr_t rb, reg_addr_t rd);
    dp_cmd_t c;
    c.op = o; c.sa = sa; c.ra = ra; c.sb = sb; c.rb = rb; c.rd = rd;
    c.start = 1'b1; c.load_in = 1'b0; c.gain_zero = 1'b0; c.out_load = 1'b0;
    return c;
  endfunction

  always_comb begin
    unique case (pc)
      5'd0:  ins = mk(OP_SUB, S_REG, R_GYRO, S_REG, R_BIAS, R_TMP);
      5'd1:  ins = mk(OP_MUL, S_REG, R_TMP, S_DT, R_ZERO, R_TMP);
      5'd2:  ins = mk(OP_ADD, S_REG, R_ANGLE, S_REG, R_TMP, R_ANGLE);
      5'd3:  ins = mk(OP_SUB, S_REG, R_ACC, S_REG, R_ANGLE, R_ERR);
      5'd4:  ins = mk(OP_SUB, S_QA, R_ZERO, S_REG, R_PAB, R_TMP);
      5'd5:  ins = mk(OP_SUB, S_REG, R_TMP, S_REG, R_PBA, R_TMP);
      5'd6:  ins = mk(OP_MUL, S_REG, R_TMP, S_DT, R_ZERO, R_TMP);
      5'd7:  ins = mk(OP_ADD, S_REG, R_PAA, S_REG, R_TMP, R_PAA);
      5'd8:  ins = mk(OP_SUB, S_REG, R_ZERO, S_REG, R_PBB, R_TMP);
      5'd9:  ins = mk(OP_MUL, S_REG, R_TMP, S_DT, R_ZERO, R_TMP);
      5'd10: ins = mk(OP_ADD, S_REG, R_PAB, S_REG, R_TMP, R_PAB);
      5'd11: ins = mk(OP_ADD, S_REG, R_PBA, S_REG, R_TMP, R_PBA);
      5'd12: ins = mk(OP_MUL, S_QB, R_ZERO, S_DT, R_ZERO, R_TMP);
      5'd13: ins = mk(OP_ADD, S_REG, R_PBB, S_REG, R_TMP, R_PBB);
      5'd14: ins = mk(OP_ADD, S_R, R_ZERO, S_REG, R_PAA, R_E);
      5'd15: begin
        ins = mk(OP_DIV, S_REG, R_PAA, S_REG, R_E, R_K0);
        ins.start = status.e_pos;
        ins.gain_zero = !status.e_pos;
      end
      5'd16: begin
        ins = mk(OP_DIV, S_REG, R_PBA, S_REG, R_E, R_K1);
        ins.start = status.e_pos;
      end
      5'd17: ins = mk(OP_MOV, S_REG, R_PAA, S_REG, R_ZERO, R_T0);
      5'd18: ins = mk(OP_MOV, S_REG, R_PAB, S_REG, R_ZERO, R_T1);
      5'd19: ins = mk(OP_MUL, S_REG, R_K0, S_REG, R_T0, R_TMP);
      5'd20: ins = mk(OP_SUB, S_REG, R_PAA, S_REG, R_TMP, R_PAA);
      5'd21: ins = mk(OP_MUL, S_REG, R_K0, S_REG, R_T1, R_TMP);
      5'd22: ins = mk(OP_SUB, S_REG, R_PAB, S_REG, R_TMP, R_PAB);
      5'd23: ins = mk(OP_MUL, S_REG, R_K1, S_REG, R_T0, R_TMP);
      5'd24: ins = mk(OP_SUB, S_REG, R_PBA, S_REG, R_TMP, R_PBA);
      5'd25: ins = mk(OP_MUL, S_REG, R_K1, S_REG, R_T1, R_TMP);
      5'd26: ins = mk(OP_SUB, S_REG, R_PBB, S_REG, R_TMP, R_PBB);
      5'd27: ins = mk(OP_MUL, S_REG, R_K0, S_REG, R_ERR, R_TMP);
      5'd28: ins = mk(OP_ADD, S_REG, R_ANGLE, S_REG, R_TMP, R_ANGLE);
      5'd29: ins = mk(OP_MUL, S_REG, R_K1, S_REG, R_ERR, R_TMP);
      5'd30: ins = mk(OP_ADD, S_REG, R_BIAS, S_REG, R_TMP, R_BIAS);
      default: ins = mk(OP_SUB, S_REG, R_GYRO, S_REG, R_BIAS, R_TMP);
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next = pc;
    cmd = ins;
    cmd.start = 1'b0;
    cmd.gain_zero = 1'b0;
    cmd.load_in = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          pc_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd = ins;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (!status.busy) begin
          if (pc == PC_W'(PROG_LEN - 1)) state_next = ST_DONE;
          else begin
            pc_next = pc + 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_DONE: begin
        // wait for the output slot to free up
        if (!out_valid || out_fire) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == ST_IDLE);

endmodule

>>> design/angle_bias_kalman_fusion_unit.sv
// channel  | fields (low bit first)                     | handshake
// s_axis   | accel_angle[31:0], gyro_rate[63:32]        | s_axis_tvalid/tready
// m_axis   | angle_estimate[31:0], rate_estimate[63:32] | m_axis_tvalid/tready
// cfg      | index 0..3, 31-bit data                    | cfg_we, no wait
// A 32-step microprogram runs on one shared unit: multiplies form four
// half-width partial products and divides are bit-serial restoring. The
// result is registered once the last step is done and the output slot is
// free, and the input is ready again from that cycle; a non-positive
// innovation variance zeroes the gains. Synchronous active-high reset.
// A held result lets the next item run; only its completion waits for the slot.
module angle_bias_kalman_fusion_unit
  import abkf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int COV_FRAC_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,   // accel_angle, gyro_rate
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*DATA_WIDTH-1:0] m_axis_tdata,   // angle_estimate, rate_estimate
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W:0]    cfg_index,
  input  logic [DATA_WIDTH-2:0] cfg_data
);

  localparam int W = DATA_WIDTH;
  localparam int F = COV_FRAC_BITS;

  logic [W-2:0] qa, qb, rn, dt;
  dp_cmd_t cmd;
  dp_status_t status;
  logic [W-1:0] angle, rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= (W-1)'(((64'd1 << F) + 64'd500) / 64'd1000);
      qb <= (W-1)'(((64'd1 << F) + 64'd100) / 64'd200);
      rn <= (W-1)'(64'd1 << (F - 1));
      dt <= (W-1)'(((64'd1 << F) + 64'd125) / 64'd250);
    end else if (cfg_we) begin
      if (cfg_index == CFG_QA) qa <= cfg_data;
      if (cfg_index == CFG_QB) qb <= cfg_data;
      if (cfg_index == CFG_R) rn <= cfg_data;
      if (cfg_index == CFG_DT) dt <= cfg_data;
    end
  end

  abkf_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid & s_axis_tready),
    .out_fire(m_axis_tvalid & m_axis_tready),
    .status, .cmd,
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid)
  );

  abkf_datapath #(.W(W), .F(F)) u_dp (
    .clk, .rst, .cmd,
    .acc_in(s_axis_tdata[W-1:0]),
    .gyro_in(s_axis_tdata[2*W-1:W]),
    .qa, .qb, .rn, .dt,
    .status,
    .angle_out(angle),
    .rate_src(rate)
  );

  assign m_axis_tdata = {rate, angle};

endmodule

>>> design/abkf_checker.sv
module abkf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && !s_axis_tvalid |=> s_axis_tready) else $error("ready dropped while idle");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");

endmodule

bind angle_bias_kalman_fusion_unit abkf_checker u_chk (.*);
